// ----- sv/mpsm_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// mpsm_pkg
// Shared constants, types and helpers of the multi-pattern string matcher.
// ----------------------------------------------------------------------------
package mpsm_pkg;

   // trie geometry
   localparam int MAX_NODES   = 4096;
   localparam int ALPHABET    = 26;
   localparam int NODE_W      = $clog2(MAX_NODES);
   localparam int LETTER_W    = 5;
   localparam int CHILD_DEPTH = MAX_NODES * ALPHABET;
   localparam int CHILD_AW    = $clog2(CHILD_DEPTH);
   localparam int COUNT_W     = 16;

   // item kinds
   localparam logic [1:0] KIND_PATTERN = 2'd0;
   localparam logic [1:0] KIND_BUILD   = 2'd1;
   localparam logic [1:0] KIND_TEXT    = 2'd2;

   // controller states
   typedef enum logic [4:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_I_READ,
      ST_I_CHECK,
      ST_I_CREAD,
      ST_I_CINC,
      ST_I_FIN,
      ST_B_INIT,
      ST_B_READ,
      ST_B_CHECK,
      ST_B_WREAD,
      ST_B_WCHECK,
      ST_B_WFAIL,
      ST_B_NEXT,
      ST_B_POP,
      ST_T_READ,
      ST_T_CHECK,
      ST_T_FAIL,
      ST_T_SUF,
      ST_T_ACC,
      ST_T_END
   } ctl_state_type;

   // datapath commands
   typedef enum logic [4:0] {
      CMD_NONE,
      CMD_CLEAR,
      CMD_ACCEPT,
      CMD_I_READ,
      CMD_I_CHECK,
      CMD_I_CREAD,
      CMD_I_CINC,
      CMD_I_FIN,
      CMD_B_INIT,
      CMD_B_READ,
      CMD_B_CHECK,
      CMD_B_WREAD,
      CMD_B_WCHECK,
      CMD_B_WFAIL,
      CMD_B_NEXT,
      CMD_B_POP,
      CMD_T_READ,
      CMD_T_CHECK,
      CMD_T_FAIL,
      CMD_T_SUF,
      CMD_T_ACC,
      CMD_T_END
   } cmd_type;

   // datapath status back to the controller
   typedef struct packed {
      logic clr_done;
      logic ins_skip;
      logic child_zero;
      logic node_full;
      logic last;
      logic letter_end;
      logic root_phase;
      logic queue_empty;
      logic walk_root;
      logic pos_root;
      logic letter_bad;
      logic suf_done;
   } status_type;

   // flat address of a child slot
   function automatic logic [CHILD_AW-1:0] child_addr(input logic [NODE_W-1:0] node,
                                                      input logic [LETTER_W-1:0] c);
      return CHILD_AW'(node) * CHILD_AW'(ALPHABET) + CHILD_AW'(c);
   endfunction

endpackage
`default_nettype wire

// ----- sv/mpsm_ctrl.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// mpsm_ctrl
// Sequencer: steps insert, build and text walks and issues datapath commands.
// ----------------------------------------------------------------------------
module mpsm_ctrl
   import mpsm_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       start,
   input  wire logic [1:0] kind,
   input  wire status_type status,
   output cmd_type         cmd,
   output logic            busy
);

   ctl_state_type state_ff, state_in;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state and commands
   always_comb begin
      state_in = state_ff;
      cmd      = CMD_NONE;
      busy     = 1'b1;
      case (state_ff)
         ST_CLEAR: begin
            cmd = CMD_CLEAR;
            if (status.clr_done) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            busy = 1'b0;
            if (start) begin
               cmd = CMD_ACCEPT;
               case (kind)
                  KIND_PATTERN: state_in = ST_I_READ;
                  KIND_BUILD:   state_in = ST_B_INIT;
                  KIND_TEXT:    state_in = ST_T_READ;
                  default:      state_in = ST_IDLE;
               endcase
            end
         end
         ST_I_READ: begin
            cmd      = CMD_I_READ;
            state_in = status.ins_skip ? ST_I_FIN : ST_I_CHECK;
         end
         ST_I_CHECK: begin
            cmd = CMD_I_CHECK;
            if (status.child_zero && status.node_full) state_in = ST_I_FIN;
            else if (status.last)                      state_in = ST_I_CREAD;
            else                                       state_in = ST_I_FIN;
         end
         ST_I_CREAD: begin
            cmd      = CMD_I_CREAD;
            state_in = ST_I_CINC;
         end
         ST_I_CINC: begin
            cmd      = CMD_I_CINC;
            state_in = ST_I_FIN;
         end
         ST_I_FIN: begin
            cmd      = CMD_I_FIN;
            state_in = ST_IDLE;
         end
         ST_B_INIT: begin
            cmd      = CMD_B_INIT;
            state_in = ST_B_READ;
         end
         ST_B_READ: begin
            cmd      = CMD_B_READ;
            state_in = ST_B_CHECK;
         end
         ST_B_CHECK: begin
            cmd = CMD_B_CHECK;
            if (status.child_zero || status.root_phase) begin
               state_in = status.letter_end ? ST_B_NEXT : ST_B_READ;
            end else begin
               state_in = ST_B_WREAD;
            end
         end
         ST_B_WREAD: begin
            cmd      = CMD_B_WREAD;
            state_in = ST_B_WCHECK;
         end
         ST_B_WCHECK: begin
            cmd = CMD_B_WCHECK;
            if (!status.child_zero || status.walk_root) begin
               state_in = status.letter_end ? ST_B_NEXT : ST_B_READ;
            end else begin
               state_in = ST_B_WFAIL;
            end
         end
         ST_B_WFAIL: begin
            cmd      = CMD_B_WFAIL;
            state_in = ST_B_WREAD;
         end
         ST_B_NEXT: begin
            cmd      = CMD_B_NEXT;
            state_in = status.queue_empty ? ST_IDLE : ST_B_POP;
         end
         ST_B_POP: begin
            cmd      = CMD_B_POP;
            state_in = ST_B_READ;
         end
         ST_T_READ: begin
            cmd      = CMD_T_READ;
            state_in = status.letter_bad ? ST_T_END : ST_T_CHECK;
         end
         ST_T_CHECK: begin
            cmd      = CMD_T_CHECK;
            state_in = (!status.child_zero || status.pos_root) ? ST_T_SUF : ST_T_FAIL;
         end
         ST_T_FAIL: begin
            cmd      = CMD_T_FAIL;
            state_in = ST_T_READ;
         end
         ST_T_SUF: begin
            cmd      = CMD_T_SUF;
            state_in = status.suf_done ? ST_T_END : ST_T_ACC;
         end
         ST_T_ACC: begin
            cmd      = CMD_T_ACC;
            state_in = ST_T_SUF;
         end
         ST_T_END: begin
            cmd      = CMD_T_END;
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule
`default_nettype wire

// ----- sv/mpsm_datapath.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// mpsm_datapath
// Trie, failure link, pattern count and queue memories with walk registers.
// ----------------------------------------------------------------------------
module mpsm_datapath
   import mpsm_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire cmd_type             cmd,
   input  wire logic [LETTER_W-1:0] req_letter,
   input  wire logic                req_last,
   output status_type              status,
   output logic                    rsp_strobe,
   output logic [COUNT_W-1:0]      rsp_match_count,
   output logic                    rsp_overflow
);

   // memories
   logic [NODE_W-1:0]  child_mem [CHILD_DEPTH];
   logic [NODE_W-1:0]  fail_mem  [MAX_NODES];
   logic [COUNT_W-1:0] count_mem [MAX_NODES];
   logic [NODE_W-1:0]  queue_mem [MAX_NODES];

   logic [NODE_W-1:0]  child_rd_ff, fail_rd_ff, queue_rd_ff;
   logic [COUNT_W-1:0] count_rd_ff;

   logic                child_we, fail_we, count_we, queue_we;
   logic [CHILD_AW-1:0] child_waddr, child_raddr;
   logic [NODE_W-1:0]   child_wdata;
   logic [NODE_W-1:0]   fail_waddr, fail_raddr, fail_wdata;
   logic [NODE_W-1:0]   count_waddr, count_raddr;
   logic [COUNT_W-1:0]  count_wdata;
   logic [NODE_W-1:0]   queue_waddr, queue_raddr, queue_wdata;

   // control registers
   logic [CHILD_AW-1:0] clr_cnt_ff, clr_cnt_in;
   logic [NODE_W-1:0]   node_total_ff, node_total_in;
   logic [NODE_W-1:0]   ins_pos_ff, ins_pos_in;
   logic                ins_drop_ff, ins_drop_in;
   logic [NODE_W-1:0]   match_pos_ff, match_pos_in;
   logic [COUNT_W-1:0]  run_total_ff, run_total_in;
   logic                ovf_ff, ovf_in;
   logic [NODE_W-1:0]   head_ff, head_in;
   logic [NODE_W-1:0]   tail_ff, tail_in;
   logic                rsp_strobe_ff, rsp_strobe_in;

   // payload registers
   logic [LETTER_W-1:0] letter_ff, letter_in;
   logic                last_ff, last_in;
   logic [NODE_W-1:0]   bx_ff, bx_in;
   logic [LETTER_W-1:0] bc_ff, bc_in;
   logic [NODE_W-1:0]   bv_ff, bv_in;
   logic [NODE_W-1:0]   bk_ff, bk_in;
   logic                root_ph_ff, root_ph_in;
   logic [NODE_W-1:0]   st_ff, st_in;
   logic [COUNT_W-1:0]  rsp_count_ff, rsp_count_in;
   logic                rsp_ovf_ff, rsp_ovf_in;

   logic              child_zero, node_full, letter_bad;
   logic [NODE_W-1:0] node_new;
   logic [COUNT_W:0]  sum;

   assign child_zero = (child_rd_ff == '0);
   assign node_full  = ({1'b0, node_total_ff} + (NODE_W+1)'(1)) >= (NODE_W+1)'(MAX_NODES);
   assign node_new   = node_total_ff + NODE_W'(1);
   assign letter_bad = (letter_ff >= LETTER_W'(ALPHABET));
   assign sum        = {1'b0, run_total_ff} + {1'b0, count_rd_ff};

   // status to the controller
   always_comb begin
      status.clr_done    = (clr_cnt_ff == CHILD_AW'(CHILD_DEPTH - 1));
      status.ins_skip    = ins_drop_ff || letter_bad;
      status.child_zero  = child_zero;
      status.node_full   = node_full;
      status.last        = last_ff;
      status.letter_end  = (bc_ff == LETTER_W'(ALPHABET - 1));
      status.root_phase  = root_ph_ff;
      status.queue_empty = (head_ff == tail_ff);
      status.walk_root   = (bv_ff == '0);
      status.pos_root    = (match_pos_ff == '0);
      status.letter_bad  = letter_bad;
      status.suf_done    = (st_ff == '0);
   end

   // command decode
   always_comb begin
      clr_cnt_in    = clr_cnt_ff;
      node_total_in = node_total_ff;
      ins_pos_in    = ins_pos_ff;
      ins_drop_in   = ins_drop_ff;
      match_pos_in  = match_pos_ff;
      run_total_in  = run_total_ff;
      ovf_in        = ovf_ff;
      head_in       = head_ff;
      tail_in       = tail_ff;
      rsp_strobe_in = 1'b0;
      letter_in     = letter_ff;
      last_in       = last_ff;
      bx_in         = bx_ff;
      bc_in         = bc_ff;
      bv_in         = bv_ff;
      bk_in         = bk_ff;
      root_ph_in    = root_ph_ff;
      st_in         = st_ff;
      rsp_count_in  = rsp_count_ff;
      rsp_ovf_in    = rsp_ovf_ff;

      child_we    = 1'b0;
      child_waddr = child_addr(ins_pos_ff, letter_ff);
      child_wdata = node_new;
      child_raddr = child_addr(ins_pos_ff, letter_ff);
      fail_we     = 1'b0;
      fail_waddr  = bk_ff;
      fail_wdata  = child_rd_ff;
      fail_raddr  = st_ff;
      count_we    = 1'b0;
      count_waddr = st_ff;
      count_wdata = '0;
      count_raddr = st_ff;
      queue_we    = 1'b0;
      queue_waddr = tail_ff;
      queue_wdata = bk_ff;
      queue_raddr = head_ff;

      case (cmd)
         CMD_CLEAR: begin
            child_we    = 1'b1;
            child_waddr = clr_cnt_ff;
            child_wdata = '0;
            if (clr_cnt_ff < CHILD_AW'(MAX_NODES)) begin
               fail_we     = 1'b1;
               fail_waddr  = clr_cnt_ff[NODE_W-1:0];
               fail_wdata  = '0;
               count_we    = 1'b1;
               count_waddr = clr_cnt_ff[NODE_W-1:0];
            end
            clr_cnt_in = clr_cnt_ff + CHILD_AW'(1);
         end
         CMD_ACCEPT: begin
            letter_in = req_letter;
            last_in   = req_last;
         end
         CMD_I_READ: begin
            if (letter_bad) ins_drop_in = 1'b1;
         end
         CMD_I_CHECK: begin
            if (child_zero) begin
               if (node_full) begin
                  ovf_in      = 1'b1;
                  ins_drop_in = 1'b1;
               end else begin
                  child_we      = 1'b1;
                  node_total_in = node_new;
                  ins_pos_in    = node_new;
               end
            end else begin
               ins_pos_in = child_rd_ff;
            end
         end
         CMD_I_CREAD: begin
            count_raddr = ins_pos_ff;
         end
         CMD_I_CINC: begin
            if (count_rd_ff != '1) begin
               count_we    = 1'b1;
               count_waddr = ins_pos_ff;
               count_wdata = count_rd_ff + COUNT_W'(1);
            end
         end
         CMD_I_FIN: begin
            if (last_ff) begin
               ins_pos_in  = '0;
               ins_drop_in = 1'b0;
            end
         end
         CMD_B_INIT: begin
            head_in    = '0;
            tail_in    = '0;
            bx_in      = '0;
            bc_in      = '0;
            root_ph_in = 1'b1;
         end
         CMD_B_READ: begin
            child_raddr = child_addr(bx_ff, bc_ff);
            fail_raddr  = bx_ff;
         end
         CMD_B_CHECK: begin
            if (child_zero) begin
               bc_in = bc_ff + LETTER_W'(1);
            end else if (root_ph_ff) begin
               // children of the root fall back to the root
               fail_we     = 1'b1;
               fail_waddr  = child_rd_ff;
               fail_wdata  = '0;
               queue_we    = 1'b1;
               queue_wdata = child_rd_ff;
               tail_in     = tail_ff + NODE_W'(1);
               bc_in       = bc_ff + LETTER_W'(1);
            end else begin
               bk_in = child_rd_ff;
               bv_in = fail_rd_ff;
            end
         end
         CMD_B_WREAD: begin
            child_raddr = child_addr(bv_ff, bc_ff);
         end
         CMD_B_WCHECK: begin
            fail_raddr = bv_ff;
            if (!child_zero || bv_ff == '0) begin
               fail_we  = 1'b1;
               queue_we = 1'b1;
               tail_in  = tail_ff + NODE_W'(1);
               bc_in    = bc_ff + LETTER_W'(1);
            end
         end
         CMD_B_WFAIL: begin
            bv_in = fail_rd_ff;
         end
         CMD_B_POP: begin
            bx_in      = queue_rd_ff;
            head_in    = head_ff + NODE_W'(1);
            bc_in      = '0;
            root_ph_in = 1'b0;
         end
         CMD_T_READ: begin
            child_raddr = child_addr(match_pos_ff, letter_ff);
            if (letter_bad) match_pos_in = '0;
         end
         CMD_T_CHECK: begin
            fail_raddr = match_pos_ff;
            if (!child_zero || match_pos_ff == '0) begin
               match_pos_in = child_rd_ff;
               st_in        = child_rd_ff;
            end
         end
         CMD_T_FAIL: begin
            match_pos_in = fail_rd_ff;
         end
         CMD_T_ACC: begin
            // add and clear one count on the suffix chain
            run_total_in = sum[COUNT_W] ? '1 : sum[COUNT_W-1:0];
            count_we     = 1'b1;
            st_in        = fail_rd_ff;
         end
         CMD_T_END: begin
            if (last_ff) begin
               rsp_strobe_in = 1'b1;
               rsp_count_in  = run_total_ff;
               rsp_ovf_in    = ovf_ff;
               run_total_in  = '0;
               match_pos_in  = '0;
            end
         end
         default: begin
         end
      endcase
   end

   // memory ports
   always_ff @(posedge clock) begin
      if (child_we) child_mem[child_waddr] <= child_wdata;
      child_rd_ff <= child_mem[child_raddr];
   end

   always_ff @(posedge clock) begin
      if (fail_we) fail_mem[fail_waddr] <= fail_wdata;
      fail_rd_ff <= fail_mem[fail_raddr];
   end

   always_ff @(posedge clock) begin
      if (count_we) count_mem[count_waddr] <= count_wdata;
      count_rd_ff <= count_mem[count_raddr];
   end

   always_ff @(posedge clock) begin
      if (queue_we) queue_mem[queue_waddr] <= queue_wdata;
      queue_rd_ff <= queue_mem[queue_raddr];
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_cnt_ff    <= '0;
         node_total_ff <= '0;
         ins_pos_ff    <= '0;
         ins_drop_ff   <= 1'b0;
         match_pos_ff  <= '0;
         run_total_ff  <= '0;
         ovf_ff        <= 1'b0;
         head_ff       <= '0;
         tail_ff       <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         clr_cnt_ff    <= clr_cnt_in;
         node_total_ff <= node_total_in;
         ins_pos_ff    <= ins_pos_in;
         ins_drop_ff   <= ins_drop_in;
         match_pos_ff  <= match_pos_in;
         run_total_ff  <= run_total_in;
         ovf_ff        <= ovf_in;
         head_ff       <= head_in;
         tail_ff       <= tail_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      letter_ff    <= letter_in;
      last_ff      <= last_in;
      bx_ff        <= bx_in;
      bc_ff        <= bc_in;
      bv_ff        <= bv_in;
      bk_ff        <= bk_in;
      root_ph_ff   <= root_ph_in;
      st_ff        <= st_in;
      rsp_count_ff <= rsp_count_in;
      rsp_ovf_ff   <= rsp_ovf_in;
   end

   assign rsp_strobe      = rsp_strobe_ff;
   assign rsp_match_count = rsp_count_ff;
   assign rsp_overflow    = rsp_ovf_ff;

   // checks
   a_ins_pos_in_trie: assert property (@(posedge clock) disable iff (reset)
      ins_pos_ff <= node_total_ff)
      else $error("insert position beyond allocated nodes");

   a_queue_order: assert property (@(posedge clock) disable iff (reset)
      head_ff <= tail_ff)
      else $error("build queue head passed tail");

   a_node_alloc: assert property (@(posedge clock) disable iff (reset)
      (cmd == CMD_I_CHECK && child_zero && !node_full)
      |=> node_total_ff == $past(node_total_ff) + NODE_W'(1))
      else $error("node allocation did not advance node total");

   a_one_cycle_word: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe_ff |=> !rsp_strobe_ff)
      else $error("result word held longer than one cycle");

endmodule
`default_nettype wire

// ----- sv/multi_pattern_string_matcher_top.sv -----
`default_nettype none
// A pattern letter reads its child slot, then follows it or allocates a node, and on the
//   last letter bumps the node's count; a text letter steps failure links and walks the
//   suffix chain, the result word registered at the end. Build visits child slots,
//   walks failure links and queues nodes; one item at a time, each step a registered
//   memory read. After reset a clearing pass zeroes the trie; busy stays high.
// Result words cannot be stalled by the receiver.
// ----------------------------------------------------------------------------
// multi_pattern_string_matcher_top
// Aho-Corasick matcher: trie insertion, failure-link build and text scanning.
// ----------------------------------------------------------------------------
module multi_pattern_string_matcher_top
   import mpsm_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                start,
   output logic                     busy,
   input  wire logic [1:0]          req_kind,
   input  wire logic [LETTER_W-1:0] req_letter,
   input  wire logic                req_last,
   output logic                     rsp_strobe,
   output logic [COUNT_W-1:0]       rsp_match_count,
   output logic                     rsp_overflow
);

   cmd_type    cmd;
   status_type status;

   // sequencer
   mpsm_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .kind   (req_kind),
      .status (status),
      .cmd    (cmd),
      .busy   (busy)
   );

   // memories and walk registers
   mpsm_datapath u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .req_letter      (req_letter),
      .req_last        (req_last),
      .status          (status),
      .rsp_strobe      (rsp_strobe),
      .rsp_match_count (rsp_match_count),
      .rsp_overflow    (rsp_overflow)
   );

endmodule
`default_nettype wire
